@@ sv/sadm_pkg.sv @@
// ----------------------------------------------------------------------------
// sadm_pkg
// Shared constants, codes and types of the slot allocator with dirty marks.
// ----------------------------------------------------------------------------
package sadm_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = SLOT_W + 1;

  localparam int MODE_W     = 3;
  localparam int IDX_W      = 12;
  localparam int OWNER_W    = 64;
  localparam int ESZ_W      = 13;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 10;
  localparam int OFFSET_W   = 22;
  localparam int PROD_W     = IDX_W + ESZ_W;

  localparam logic [ESZ_W-1:0] ESZ_RESET = ESZ_W'(256);

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UPDATE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLUSH   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic               dirty;
    logic               active;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic              rd_en;
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] push_slot;
  } fl_req_t;

  typedef struct packed {
    logic              empty;
    logic [SLOT_W-1:0] head_slot;
  } fl_stat_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

endpackage

@@ sv/sadm_if.sv @@
// ----------------------------------------------------------------------------
// sadm_if
// Valid/ready channels of the slot allocator: request items and result items.
// ----------------------------------------------------------------------------
interface sadm_in_if;
  import sadm_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [IDX_W-1:0]   slot_index;
  logic [OWNER_W-1:0] owner_id;

  modport source (output valid, output mode, output slot_index, output owner_id,
                  input ready);
  modport sink   (input valid, input mode, input slot_index, input owner_id,
                  output ready);
endinterface

interface sadm_out_if;
  import sadm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot_out;
  logic [OFFSET_W-1:0]   byte_offset;
  logic                  pending_flush;

  modport source (output valid, output status, output slot_out, output byte_offset,
                  output pending_flush, input ready);
  modport sink   (input valid, input status, input slot_out, input byte_offset,
                  input pending_flush, output ready);
endinterface

@@ sv/sadm_ram.sv @@
// ----------------------------------------------------------------------------
// sadm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sadm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule

@@ sv/sadm_free_list.sv @@
// ----------------------------------------------------------------------------
// sadm_free_list
// Circular queue of released slots held in a RAM, with head, tail and count.
// ----------------------------------------------------------------------------
module sadm_free_list (
  input  logic              clk,
  input  logic              rst_n,
  input  sadm_pkg::fl_req_t  req,
  output sadm_pkg::fl_stat_t stat
);
  import sadm_pkg::*;

  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push_ok;
  logic              pop_ok;
  logic [SLOT_W-1:0] head_slot;

  function automatic logic [SLOT_W-1:0] wrap_next(input logic [SLOT_W-1:0] p);
    if (p == SLOT_W'(SLOT_COUNT - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign push_ok = req.push && (count_r != CNT_W'(SLOT_COUNT));
  assign pop_ok  = req.pop && (count_r != '0);

  always_comb begin
    head_nxt  = pop_ok ? wrap_next(head_r) : head_r;
    tail_nxt  = push_ok ? wrap_next(tail_r) : tail_r;
    count_nxt = count_r;
    case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  sadm_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (tail_r),
    .wdata (req.push_slot),
    .re    (req.rd_en),
    .raddr (head_r),
    .rdata (head_slot)
  );

  assign stat = '{empty: (count_r == '0), head_slot: head_slot};

endmodule

@@ sv/slot_allocator_with_dirty_marks.sv @@
// ----------------------------------------------------------------------------
// slot_allocator_with_dirty_marks
// Slot pool allocator: free-list reuse, bump pointer, active/dirty marks,
// owner ids and binding offsets, around one slot RAM and one free-list RAM.
//
//   channel  | dir | handshake      | payload
//   in_ch    | in  | valid/ready    | mode, slot_index, owner_id
//   out_ch   | out | valid/ready    | status, slot_out, byte_offset, pending_flush
//   cfg_     | in  | cfg_we         | cfg_wdata (entry_size_bytes)
//
// Allocate, release, update, query: no new item is taken until the last is done;
// the slot RAM and free-list RAM are read in the accept cycle, and write-back
// and result load follow in the execute state. Flush: one slot RAM entry swept per cycle.
// After reset a clearing pass zeroes every slot RAM entry with in_ch.ready low.
// A stalled result holds the item in its write-back cycle until out_ch frees.
// ----------------------------------------------------------------------------
module slot_allocator_with_dirty_marks (
  input  logic                       clk,
  input  logic                       rst_n,
  sadm_in_if.sink                    in_ch,
  sadm_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [sadm_pkg::ESZ_W-1:0] cfg_wdata
);
  import sadm_pkg::*;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    sweep_cnt_r, sweep_cnt_nxt;
  logic                fl_wr_vld_r, fl_wr_vld_nxt;
  logic [SLOT_W-1:0]   fl_wr_addr_r;
  logic [CNT_W-1:0]    next_unused_r, next_unused_nxt;
  logic                pending_r, pending_nxt;
  logic [ESZ_W-1:0]    esz_r;

  logic [MODE_W-1:0]   req_mode_r;
  logic [IDX_W-1:0]    req_sidx_r;
  logic [OWNER_W-1:0]  req_owner_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic [OFFSET_W-1:0]   out_offset_r, out_offset_nxt;
  logic                  out_pend_r;

  logic                sr_we;
  logic [SLOT_W-1:0]   sr_waddr;
  slot_entry_t         sr_wdata;
  logic                sr_re;
  logic [SLOT_W-1:0]   sr_raddr;
  slot_entry_t         sr_rdata;

  fl_req_t             fl_req;
  fl_stat_t            fl_stat;

  logic                accept;
  logic                out_free;
  logic                exec_go;
  logic                sweep_issue;
  logic                live;
  logic [PROD_W-1:0]   prod;

  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign exec_go     = (state_r == S_EXEC) && out_free;
  assign sweep_issue = (state_r == S_FLUSH) && (sweep_cnt_r != CNT_W'(SLOT_COUNT));
  assign live        = ((IDX_W + 1)'(req_sidx_r) < (IDX_W + 1)'(SLOT_COUNT))
                       && sr_rdata.active;
  assign prod        = PROD_W'(req_sidx_r) * PROD_W'(esz_r);

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    sweep_cnt_nxt   = sweep_cnt_r;
    fl_wr_vld_nxt   = sweep_issue;
    next_unused_nxt = next_unused_r;
    pending_nxt     = pending_r;
    out_status_nxt  = ST_OK;
    out_slot_nxt    = '0;
    out_offset_nxt  = '0;

    sr_we    = 1'b0;
    sr_waddr = '0;
    sr_wdata = '0;
    sr_re    = 1'b0;
    sr_raddr = in_ch.slot_index[SLOT_W-1:0];

    fl_req.rd_en     = accept;
    fl_req.pop       = 1'b0;
    fl_req.push      = 1'b0;
    fl_req.push_slot = req_sidx_r[SLOT_W-1:0];

    case (state_r)
      S_CLEAR: begin
        sr_we    = 1'b1;
        sr_waddr = sweep_cnt_r[SLOT_W-1:0];
        if (sweep_cnt_r == CNT_W'(SLOT_COUNT - 1)) begin
          sweep_cnt_nxt = '0;
          state_nxt     = S_IDLE;
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          sr_re         = 1'b1;
          sweep_cnt_nxt = '0;
          state_nxt     = (in_ch.mode == MODE_FLUSH) ? S_FLUSH : S_EXEC;
        end
      end
      S_FLUSH: begin
        sr_re    = sweep_issue;
        sr_raddr = sweep_cnt_r[SLOT_W-1:0];
        if (sweep_issue) begin
          sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        end
        if (fl_wr_vld_r) begin
          sr_we          = 1'b1;
          sr_waddr       = fl_wr_addr_r;
          sr_wdata       = sr_rdata;
          sr_wdata.dirty = 1'b0;
          if (fl_wr_addr_r == SLOT_W'(SLOT_COUNT - 1)) begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          case (req_mode_r)
            MODE_ALLOC: begin
              sr_wdata.owner  = req_owner_r;
              sr_wdata.dirty  = 1'b1;
              sr_wdata.active = 1'b1;
              if (!fl_stat.empty) begin
                fl_req.pop   = 1'b1;
                sr_we        = 1'b1;
                sr_waddr     = fl_stat.head_slot;
                out_slot_nxt = SLOT_OUT_W'(fl_stat.head_slot);
              end else if (next_unused_r != CNT_W'(SLOT_COUNT)) begin
                next_unused_nxt = next_unused_r + 1'b1;
                sr_we           = 1'b1;
                sr_waddr        = next_unused_r[SLOT_W-1:0];
                out_slot_nxt    = SLOT_OUT_W'(next_unused_r);
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            MODE_RELEASE: begin
              out_slot_nxt = SLOT_OUT_W'(req_sidx_r);
              if (live) begin
                sr_we       = 1'b1;
                sr_waddr    = req_sidx_r[SLOT_W-1:0];
                fl_req.push = 1'b1;
              end else begin
                out_status_nxt = ST_BAD;
              end
            end
            MODE_UPDATE: begin
              out_slot_nxt = SLOT_OUT_W'(req_sidx_r);
              if (live) begin
                sr_we          = 1'b1;
                sr_waddr       = req_sidx_r[SLOT_W-1:0];
                sr_wdata       = sr_rdata;
                sr_wdata.dirty = 1'b1;
                pending_nxt    = 1'b1;
              end else begin
                out_status_nxt = ST_BAD;
              end
            end
            MODE_QUERY: begin
              out_slot_nxt   = SLOT_OUT_W'(req_sidx_r);
              out_offset_nxt = prod[OFFSET_W-1:0];
              if (!live) begin
                out_status_nxt = ST_BAD;
              end
            end
            MODE_FLUSH: begin
              pending_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      sweep_cnt_r   <= '0;
      fl_wr_vld_r   <= 1'b0;
      next_unused_r <= '0;
      pending_r     <= 1'b0;
      esz_r         <= ESZ_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sweep_cnt_r   <= sweep_cnt_nxt;
      fl_wr_vld_r   <= fl_wr_vld_nxt;
      next_unused_r <= next_unused_nxt;
      pending_r     <= pending_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        esz_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    fl_wr_addr_r <= sweep_cnt_r[SLOT_W-1:0];
    if (accept) begin
      req_mode_r  <= in_ch.mode;
      req_sidx_r  <= in_ch.slot_index;
      req_owner_r <= in_ch.owner_id;
    end
    if (exec_go) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_offset_r <= out_offset_nxt;
      out_pend_r   <= pending_nxt;
    end
  end

  sadm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (sr_we),
    .waddr (sr_waddr),
    .wdata (sr_wdata),
    .re    (sr_re),
    .raddr (sr_raddr),
    .rdata (sr_rdata)
  );

  sadm_free_list u_free_list (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fl_req),
    .stat  (fl_stat)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.slot_out      = out_slot_r;
  assign out_ch.byte_offset   = out_offset_r;
  assign out_ch.pending_flush = out_pend_r;

endmodule

@@ sv/sadm_checker.sv @@
// ----------------------------------------------------------------------------
// sadm_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sadm_checker (
  input logic        clk,
  input logic        rst_n,
  sadm_in_if.sink    in_ch,
  sadm_out_if.source out_ch
);
  import sadm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status)
      && $stable(out_ch.slot_out) && $stable(out_ch.byte_offset)
      && $stable(out_ch.pending_flush))
    else $error("result item changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second item taken while one is in work");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ST_FULL) |->
      (out_ch.slot_out == '0) && (out_ch.byte_offset == '0))
    else $error("pool-full result carries a slot or offset");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ch.ready && !out_ch.valid)
    else $error("item traffic during clearing pass");

endmodule

bind slot_allocator_with_dirty_marks sadm_checker u_sadm_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
